// ===== design/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg: shared types and constants
// Request/response structs, codes and sizes for the Huffman code block.
// ----------------------------------------------------------------------------
package hcb_pkg;
  localparam int MaxSymbols = 16;
  localparam int NodeCap = 2 * MaxSymbols - 1;
  localparam int LeafW = $clog2(MaxSymbols + 1);
  localparam int NodeW = $clog2(NodeCap);
  localparam int SlotW = $clog2(MaxSymbols);
  localparam int WgtW = 20;
  localparam int CodeW = 15;
  localparam int LenW = 4;

  localparam logic [2:0] REQ_LOAD = 3'd0;
  localparam logic [2:0] REQ_BUILD = 3'd1;
  localparam logic [2:0] REQ_ENCODE = 3'd2;
  localparam logic [2:0] REQ_DECODE = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_CODE = 2'd2;
  localparam logic [1:0] KIND_SYM = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_FEW = 3'd2;
  localparam logic [2:0] ST_NOT_BUILT = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_PARTIAL = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] symbol_in;
    logic [15:0] weight_in;
    logic code_bit_in;
    logic bit_last;
  } req_t;

  typedef struct packed {
    logic [1:0] resp_kind;
    logic [2:0] status;
    logic [7:0] symbol_out;
    logic [CodeW-1:0] code_word;
    logic [LenW-1:0] code_len;
  } resp_t;

  // compare result handed from the scan unit to the sequencer
  typedef struct packed {
    logic done;
    logic [SlotW-1:0] best_slot;
    logic [NodeW-1:0] best_node;
  } scan_t;
endpackage

// ===== design/hcb_scan.sv =====
// ----------------------------------------------------------------------------
// hcb_scan: shared min-search unit
// Walks the active list one slot per cycle, keeping the lightest node
// (ties to the lower node index).
// ----------------------------------------------------------------------------
module hcb_scan (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [hcb_pkg::LeafW-1:0] count,
  input  logic [hcb_pkg::NodeW-1:0] cand_node,
  input  logic [hcb_pkg::WgtW-1:0] cand_wgt,
  output logic [hcb_pkg::SlotW-1:0] slot,
  output hcb_pkg::scan_t res
);
  logic busy;
  logic [hcb_pkg::LeafW-1:0] idx;
  logic [hcb_pkg::WgtW-1:0] best_wgt;
  logic better;

  assign slot = idx[hcb_pkg::SlotW-1:0];
  assign better = (idx == '0) || (cand_wgt < best_wgt) ||
                  (cand_wgt == best_wgt && cand_node < res.best_node);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res.done <= 1'b0;
      idx <= '0;
    end else begin
      // pulse after the last slot has been compared
      res.done <= busy && !go && (idx + 1'b1 >= count);
      if (go) begin
        busy <= 1'b1;
        idx <= '0;
      end else if (busy) begin
        if (better) begin
          best_wgt <= cand_wgt;
          res.best_node <= cand_node;
          res.best_slot <= idx[hcb_pkg::SlotW-1:0];
        end
        if (idx + 1'b1 >= count) busy <= 1'b0;
        idx <= idx + 1'b1;
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    res.done |=> !res.done) else $error("scan done not a pulse");
  a_no_go_busy: assert property (@(posedge clk) disable iff (rst)
    go |=> !res.done) else $error("scan done right after go");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx < hcb_pkg::LeafW'(hcb_pkg::MaxSymbols)) else $error("scan index range");
endmodule

// ===== design/huffman_code_build_encode_decode.sv =====
// ----------------------------------------------------------------------------
// huffman_code_build_encode_decode: Huffman code builder, encoder, decoder
// Loads symbol/weight leaves, builds the code tree, encodes and decodes.
// ----------------------------------------------------------------------------
// Usage: present a request on req with start high while busy is low; it is
// taken at that edge. Requests: load leaf, build, encode symbol, decode one
// bit, clear. At most one result per request appears on resp for exactly one
// cycle with resp_valid high; the receiver cannot stall.
// Sequence after acceptance: a load or clear finishes in the execute state.
// Error and not-built results are set there and presented from the response
// state; a decode bit that reaches a leaf or drops a partial code passes
// through the decode state first, and one that stops on an inner node goes
// back to idle from it. An encode walks the leaves in order until it hits the
// symbol or passes the last leaf (unknown symbol). A build of n leaves does
// n-1 merges; each merge runs two scans of the active list through the single
// compare unit, a merge step and a walk of the n leaf codes, and build done
// follows. A new request can be taken in the cycle a result is presented.
// Reset (rst, synchronous) and the clear request empty the table and mark the
// tree not built; storage contents stay undefined until written.
// ----------------------------------------------------------------------------
module huffman_code_build_encode_decode (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  hcb_pkg::req_t req,
  output logic busy,
  output logic resp_valid,
  output hcb_pkg::resp_t resp
);
  localparam int LW = hcb_pkg::LeafW;
  localparam int NW = hcb_pkg::NodeW;
  localparam int SW = hcb_pkg::SlotW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EXEC  = 10'b0000000010,
    S_INIT  = 10'b0000000100,
    S_SCANP = 10'b0000001000,
    S_SCANQ = 10'b0000010000,
    S_MERGE = 10'b0000100000,
    S_CODES = 10'b0001000000,
    S_ENC   = 10'b0010000000,
    S_DEC   = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_t;

  state_t state;
  hcb_pkg::req_t r;
  hcb_pkg::resp_t rsp;

  logic [hcb_pkg::WgtW-1:0] node_weight [hcb_pkg::NodeCap];
  logic [NW-1:0] node_left [hcb_pkg::NodeCap];
  logic [NW-1:0] node_right [hcb_pkg::NodeCap];
  logic [7:0] leaf_symbol [hcb_pkg::MaxSymbols];
  logic [NW-1:0] active_nodes [hcb_pkg::MaxSymbols];
  logic [NW-1:0] top [hcb_pkg::MaxSymbols];
  logic [hcb_pkg::CodeW-1:0] leaf_code [hcb_pkg::MaxSymbols];
  logic [hcb_pkg::LenW-1:0] leaf_code_len [hcb_pkg::MaxSymbols];

  logic [LW-1:0] leaf_count, active_count, k, merges;
  logic [NW-1:0] root_node, decode_cursor, next_node, p_node, q_node;
  logic tree_built;
  logic scan_go, scan_go_next;
  logic [SW-1:0] scan_slot;
  hcb_pkg::scan_t scan_res;

  hcb_scan u_scan (
    .clk(clk), .rst(rst), .go(scan_go), .count(active_count),
    .cand_node(active_nodes[scan_slot]),
    .cand_wgt(node_weight[active_nodes[scan_slot]]),
    .slot(scan_slot), .res(scan_res)
  );

  assign busy = (state != S_IDLE);
  assign resp = rsp;

  logic [NW-1:0] cur, nxt;
  always_comb begin
    cur = decode_cursor;
    if (NW'(leaf_count) > cur || cur >= NW'(hcb_pkg::NodeCap)) cur = root_node;
    nxt = r.code_bit_in ? node_right[cur] : node_left[cur];
  end

  // start a scan after init, after the first pick and before each later merge
  always_comb begin
    scan_go_next = 1'b0;
    if (state == S_INIT && k + 1'b1 == leaf_count) scan_go_next = 1'b1;
    if (state == S_SCANP && scan_res.done) scan_go_next = 1'b1;
    if (state == S_CODES && k + 1'b1 == leaf_count && merges + LW'(2) != leaf_count)
      scan_go_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      resp_valid <= 1'b0;
      leaf_count <= '0;
      active_count <= '0;
      root_node <= '0;
      tree_built <= 1'b0;
      decode_cursor <= '0;
      scan_go <= 1'b0;
    end else begin
      resp_valid <= (state == S_RESP);
      scan_go <= scan_go_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            rsp <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (r.req_type)
            hcb_pkg::REQ_LOAD: begin
              if (leaf_count >= LW'(hcb_pkg::MaxSymbols)) begin
                rsp.resp_kind <= hcb_pkg::KIND_LOAD;
                rsp.status <= hcb_pkg::ST_FULL;
                state <= S_RESP;
              end else begin
                leaf_symbol[leaf_count[SW-1:0]] <= r.symbol_in;
                node_weight[NW'(leaf_count)] <= hcb_pkg::WgtW'(r.weight_in);
                leaf_count <= leaf_count + 1'b1;
                tree_built <= 1'b0;
                decode_cursor <= '0;
                state <= S_IDLE;
              end
            end
            hcb_pkg::REQ_BUILD: begin
              rsp.resp_kind <= hcb_pkg::KIND_BUILD;
              if (leaf_count < LW'(2)) begin
                rsp.status <= hcb_pkg::ST_FEW;
                tree_built <= 1'b0;
                state <= S_RESP;
              end else begin
                k <= '0;
                state <= S_INIT;
              end
            end
            hcb_pkg::REQ_ENCODE: begin
              rsp.resp_kind <= hcb_pkg::KIND_CODE;
              k <= '0;
              if (!tree_built) begin
                rsp.status <= hcb_pkg::ST_NOT_BUILT;
                state <= S_RESP;
              end else state <= S_ENC;
            end
            hcb_pkg::REQ_DECODE: begin
              rsp.resp_kind <= hcb_pkg::KIND_SYM;
              if (!tree_built) begin
                rsp.status <= hcb_pkg::ST_NOT_BUILT;
                state <= S_RESP;
              end else state <= S_DEC;
            end
            hcb_pkg::REQ_CLEAR: begin
              leaf_count <= '0;
              active_count <= '0;
              root_node <= '0;
              tree_built <= 1'b0;
              decode_cursor <= '0;
              state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_INIT: begin
          active_nodes[k[SW-1:0]] <= NW'(k);
          top[k[SW-1:0]] <= NW'(k);
          leaf_code[k[SW-1:0]] <= '0;
          leaf_code_len[k[SW-1:0]] <= '0;
          k <= k + 1'b1;
          if (k + 1'b1 == leaf_count) begin
            active_count <= leaf_count;
            next_node <= NW'(leaf_count);
            merges <= '0;
            state <= S_SCANP;
          end
        end
        S_SCANP: begin
          if (scan_res.done) begin
            // remove lightest: move last entry into its slot
            p_node <= scan_res.best_node;
            active_nodes[scan_res.best_slot] <= active_nodes[SW'(active_count - 1'b1)];
            active_count <= active_count - 1'b1;
            state <= S_SCANQ;
          end
        end
        S_SCANQ: begin
          if (scan_res.done) begin
            q_node <= scan_res.best_node;
            active_nodes[scan_res.best_slot] <= active_nodes[SW'(active_count - 1'b1)];
            active_count <= active_count - 1'b1;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          node_weight[next_node] <= node_weight[p_node] + node_weight[q_node];
          node_left[next_node] <= p_node;
          node_right[next_node] <= q_node;
          active_nodes[SW'(active_count)] <= next_node;
          active_count <= active_count + 1'b1;
          k <= '0;
          state <= S_CODES;
        end
        S_CODES: begin
          if (top[k[SW-1:0]] == p_node || top[k[SW-1:0]] == q_node) begin
            if (top[k[SW-1:0]] == q_node)
              leaf_code[k[SW-1:0]] <= leaf_code[k[SW-1:0]] |
                (hcb_pkg::CodeW'(1) << leaf_code_len[k[SW-1:0]]);
            leaf_code_len[k[SW-1:0]] <= leaf_code_len[k[SW-1:0]] + 1'b1;
            top[k[SW-1:0]] <= next_node;
          end
          k <= k + 1'b1;
          if (k + 1'b1 == leaf_count) begin
            next_node <= next_node + 1'b1;
            merges <= merges + 1'b1;
            if (merges + LW'(2) == leaf_count) begin
              root_node <= next_node;
              decode_cursor <= next_node;
              tree_built <= 1'b1;
              state <= S_RESP;
            end else begin
              state <= S_SCANP;
            end
          end
        end
        S_ENC: begin
          if (leaf_symbol[k[SW-1:0]] == r.symbol_in) begin
            rsp.code_word <= leaf_code[k[SW-1:0]];
            rsp.code_len <= leaf_code_len[k[SW-1:0]];
            state <= S_RESP;
          end else if (k + 1'b1 == leaf_count) begin
            rsp.status <= hcb_pkg::ST_UNKNOWN;
            state <= S_RESP;
          end
          k <= k + 1'b1;
        end
        S_DEC: begin
          if (nxt < NW'(leaf_count)) begin
            decode_cursor <= root_node;
            rsp.symbol_out <= leaf_symbol[nxt[SW-1:0]];
            state <= S_RESP;
          end else if (r.bit_last) begin
            decode_cursor <= root_node;
            rsp.status <= hcb_pkg::ST_PARTIAL;
            state <= S_RESP;
          end else begin
            decode_cursor <= nxt;
            state <= S_IDLE;
          end
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_resp: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> state == S_IDLE) else $error("response outside idle");
  a_resp_gap: assert property (@(posedge clk) disable iff (rst)
    resp_valid |=> !resp_valid) else $error("back to back responses");
  a_built_root: assert property (@(posedge clk) disable iff (rst)
    tree_built |-> root_node >= NW'(leaf_count)) else $error("root inside leaves");
  a_leaf_max: assert property (@(posedge clk) disable iff (rst)
    leaf_count <= LW'(hcb_pkg::MaxSymbols)) else $error("leaf count overflow");
endmodule
